/* rtl/scrf_pkg.sv */
`default_nettype none
package scrf_pkg;

  // fixed field widths
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned ANGLE_W = 10;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_MAX_DELAY   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_PULSE_WIDTH = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] MAX_DELAY_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] PULSE_WIDTH_RST = 16'd500;

  typedef struct packed {
    logic [CHAN_W-1:0]  zero_cross_inputs;
    logic [ANGLE_W-1:0] angle_sample;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] gate_drive;
    logic [CHAN_W-1:0] armed_mask;
  } out_item_t;

  // tick levels with their scaled firing delay
  typedef struct packed {
    logic [CHAN_W-1:0] levels;
    logic [CFG_W-1:0]  delay;
  } tick_t;

  // per-channel flags after a tick
  typedef struct packed {
    logic gate;
    logic armed;
  } chan_state_t;

endpackage
`default_nettype wire

/* rtl/scrf_delay_scale.sv */
`default_nettype none
module scrf_delay_scale #(
  parameter int unsigned ANGLE_FULL_SCALE = 1023
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              in_vld,
  input  wire logic [scrf_pkg::CHAN_W-1:0]       in_levels,
  input  wire logic [scrf_pkg::ANGLE_W-1:0]      in_angle,
  input  wire logic [scrf_pkg::CFG_W-1:0]        max_delay,
  output logic                                   out_vld,
  output scrf_pkg::tick_t                        out_tick
);
  import scrf_pkg::*;

  localparam int unsigned PW = ANGLE_W + CFG_W;
  // largest sample the angle field can carry
  localparam int unsigned ANGLE_MAX = (1 << ANGLE_W) - 1;
  // saturation point, clamped to what the field can hold
  localparam logic [ANGLE_W-1:0] FULL =
    ANGLE_W'((ANGLE_FULL_SCALE < ANGLE_MAX) ? ANGLE_FULL_SCALE : ANGLE_MAX);
  // floor(2^PW / full scale): estimate is exact or one low
  localparam logic [PW:0] RECIP = (PW+1)'((64'(1) << PW) / ANGLE_FULL_SCALE);

  logic                    b_vld_r, c_vld_r, d_vld_r;
  logic [CHAN_W-1:0]       b_lv_r, c_lv_r, d_lv_r;
  logic [PW-1:0]           b_prod_r, c_prod_r;
  logic [CFG_W-1:0]        c_qest_r, d_delay_r;
  logic [ANGLE_W-1:0]      angle_sat;
  logic [2*PW:0]           recip_prod;
  logic [PW-1:0]           rem;
  logic [CFG_W-1:0]        delay_nxt;

  // saturate the angle to full scale
  assign angle_sat = (in_angle > FULL) ? FULL : in_angle;

  // quotient estimate by reciprocal
  assign recip_prod = (2*PW+1)'(b_prod_r) * (2*PW+1)'(RECIP);

  // one correction step
  assign rem = c_prod_r - PW'(PW'(c_qest_r) * PW'(ANGLE_FULL_SCALE));
  assign delay_nxt = (rem >= PW'(ANGLE_FULL_SCALE)) ? c_qest_r + 1'b1 : c_qest_r;

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= in_vld;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  // data pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      b_lv_r    <= in_levels;
      b_prod_r  <= PW'(angle_sat) * PW'(max_delay);
      c_lv_r    <= b_lv_r;
      c_prod_r  <= b_prod_r;
      c_qest_r  <= recip_prod[PW +: CFG_W];
      d_lv_r    <= c_lv_r;
      d_delay_r <= delay_nxt;
    end
  end

  assign out_vld         = d_vld_r;
  assign out_tick.levels = d_lv_r;
  assign out_tick.delay  = d_delay_r;

endmodule
`default_nettype wire

/* rtl/scrf_channel.sv */
`default_nettype none
module scrf_channel #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [TIMER_BITS-1:0]         now,
  input  wire logic                          rise,
  input  wire logic [scrf_pkg::CFG_W-1:0]    delay,
  input  wire logic [scrf_pkg::CFG_W-1:0]    pulse_width,
  output scrf_pkg::chan_state_t              state_nxt
);
  import scrf_pkg::*;

  localparam int unsigned CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  armed_r, pulse_on_r;
  logic [TIMER_BITS-1:0] arm_time_r, pulse_time_r;
  logic [TIMER_BITS-1:0] pulse_age, arm_age, arm_t_mid;
  logic                  pulse_mid, arm_set, armed_mid, fire, pulse_start;
  logic                  armed_nxt, pulse_nxt;

  // end a pulse that has run its width
  assign pulse_age = now - pulse_time_r;
  assign pulse_mid = pulse_on_r && (CW'(pulse_age) < CW'(pulse_width));

  // arm on a rising edge, ignored while already armed
  assign arm_set   = rise && !armed_r;
  assign armed_mid = armed_r || rise;
  assign arm_t_mid = arm_set ? now : arm_time_r;

  // fire once the delay is reached; lost if a pulse is still running
  assign arm_age     = now - arm_t_mid;
  assign fire        = armed_mid && (CW'(arm_age) >= CW'(delay));
  assign pulse_start = fire && !pulse_mid;
  assign armed_nxt   = armed_mid && !fire;
  assign pulse_nxt   = pulse_mid || pulse_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      pulse_on_r <= 1'b0;
    end else if (step) begin
      armed_r    <= armed_nxt;
      pulse_on_r <= pulse_nxt;
    end
  end

  // time stamps are only read while their flag is set
  always_ff @(posedge clk) begin
    if (step) begin
      arm_time_r <= arm_t_mid;
      if (pulse_start) begin
        pulse_time_r <= now;
      end
    end
  end

  assign state_nxt.gate  = pulse_nxt;
  assign state_nxt.armed = armed_nxt;

endmodule
`default_nettype wire

/* rtl/six_channel_thyristor_firing_unit.sv */
`default_nettype none
// Phase-angle firing unit for six thyristor gates.
// Input channel (in_valid/in_ready/in_data): one item per timer tick with the
// sampled zero-crossing levels and a firing-angle sample. The angle is scaled
// to a delay of angle * max_delay / full scale ticks.
// Result channel (out_valid/out_ready/out_data): one item per tick with the
// gate pulse states and the armed channels after that tick.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 is the maximum delay,
// index 1 the gate pulse width; other indexes are ignored. Write only while
// no item is in flight.
// Throughput is one item per cycle while the receiver does not stall. A result
// passes the input register, multiply, reciprocal multiply, correction
// of the constant division, then the channel update into the result register.
// When the receiver stalls the whole pipeline holds and in_ready drops once
// the result register is full; nothing is lost.
// Reset clears the tick counter, the previous levels, all armed and pulse
// flags and the pipeline valids, and loads the register defaults.
module six_channel_thyristor_firing_unit #(
  parameter int unsigned CHANNELS         = 6,
  parameter int unsigned TIMER_BITS       = 16,
  parameter int unsigned ANGLE_FULL_SCALE = 1023
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire scrf_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output scrf_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [scrf_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [scrf_pkg::CFG_W-1:0]    cfg_wdata
);
  import scrf_pkg::*;

  // channels at or beyond CHANNELS never see an edge
  localparam int unsigned LIVE = (CHANNELS < CHAN_W) ? CHANNELS : CHAN_W;
  localparam logic [CHAN_W-1:0] LIVE_MASK = CHAN_W'((1 << LIVE) - 1);

  logic                  adv, step;
  logic                  a_vld_r, out_valid_r;
  in_item_t              a_item_r;
  out_item_t             out_data_r;
  logic [CFG_W-1:0]      max_delay_r, pulse_width_r;
  logic [TIMER_BITS-1:0] tick_r;
  logic [CHAN_W-1:0]     prev_r, levels, rise, gates, arms;
  logic                  d_vld;
  tick_t                 d_tick;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign step     = adv && d_vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r   <= MAX_DELAY_RST;
      pulse_width_r <= PULSE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_DELAY:   max_delay_r   <= cfg_wdata;
        CFG_PULSE_WIDTH: pulse_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r <= in_data;
    end
  end

  // angle to delay scaling
  scrf_delay_scale #(
    .ANGLE_FULL_SCALE(ANGLE_FULL_SCALE)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (a_vld_r),
    .in_levels (a_item_r.zero_cross_inputs),
    .in_angle  (a_item_r.angle_sample),
    .max_delay (max_delay_r),
    .out_vld   (d_vld),
    .out_tick  (d_tick)
  );

  // edge detect against the previous tick
  assign levels = d_tick.levels & LIVE_MASK;
  assign rise   = levels & ~prev_r;

  // per-channel arming and gate pulses
  for (genvar g = 0; g < CHAN_W; g++) begin : g_chan
    if (g < LIVE) begin : g_live
      chan_state_t st;
      scrf_channel #(
        .TIMER_BITS(TIMER_BITS)
      ) u_chan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .now         (tick_r),
        .rise        (rise[g]),
        .delay       (d_tick.delay),
        .pulse_width (pulse_width_r),
        .state_nxt   (st)
      );
      assign gates[g] = st.gate;
      assign arms[g]  = st.armed;
    end else begin : g_idle
      assign gates[g] = 1'b0;
      assign arms[g]  = 1'b0;
    end
  end

  // tick counter, previous levels and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_vld;
      if (d_vld) begin
        tick_r <= tick_r + 1'b1;
        prev_r <= levels;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r.gate_drive <= gates;
      out_data_r.armed_mask <= arms;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> tick_r == $past(tick_r) + 1'b1)
    else $error("tick counter did not advance with a tick");

  a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(tick_r))
    else $error("tick counter moved without a tick");

  a_delay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld |-> d_tick.delay <= max_delay_r)
    else $error("scaled delay above maximum delay");

endmodule
`default_nettype wire
